/* src/rzn_pkg.sv */
// shared types and constants of the row z-score normalizer
package rzn_pkg;

  // field widths of the stream payloads and of the scaled root
  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 8;
  localparam int ZW          = 24;
  localparam int IN_DATA_W   = 24;
  localparam int ROOT_W      = 32;
  localparam int ROOT_FRAC_W = 16;

  // command codes carried on the input tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // saturation limits of the z-score
  localparam logic [ZW-1:0] Z_POS_MAX = 24'h7f_ffff;
  localparam logic [ZW-1:0] Z_NEG_MAG = 24'h80_0000;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SQUARE,
    ST_DIFF,
    ST_ROOT,
    ST_SAVE,
    ST_FETCH,
    ST_PREP,
    ST_RANGE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

endpackage

/* src/rzn_sub_unit.sv */
// shared compare and subtract unit for the root, range check and divide steps
module rzn_sub_unit
  import rzn_pkg::*;
#(
  parameter int W = 35
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge_o,
  output logic [W-1:0] diff_o
);

  logic [W:0] wide;

  // one extra bit gives the borrow, which is the compare result
  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~wide[W];
  assign diff_o = wide[W-1:0];

endmodule

/* src/rzn_row_mem.sv */
// sample store of one row, one write port and one registered read port
module rzn_row_mem
  import rzn_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/row_zscore_normalizer_top.sv */
// row z-score normalizer: sample store, running sums and sequencer
//
// Input stream s_axis: tuser is the command, write (store sample_value as
// the next sample of the row) or read (return the sample at read_index as
// a z-score). Output stream m_axis carries one result for each read:
// tdata is the z-score (signed, 16 fraction bits), tuser says whether the
// row was complete and the index in range.
// A write passes the accumulate state before the next request; the write
// that fills the row then runs the square and difference states and the
// square root in RW = ceil((DW + 16) / 2) shared subtract steps.
// A read of a complete row passes memory fetch, distance, range check and
// 24 restoring divide steps on the same unit, the divide skipped when the
// result saturates. A read of an incomplete or zero-variance row, or out
// of range, goes straight to finish. s_axis_tready is high only in idle.
// The output register holds a result until m_axis_tready takes it; the
// next request is accepted meanwhile, and its result waits in the
// sequencer until the output register frees up.
// Reset clears sums, fill count, root, row flag and the output valid;
// the sample store is not cleared, a read only gets a valid z-score once
// every entry of the row has been written.
module row_zscore_normalizer_top
  import rzn_pkg::*;
#(
  parameter int ROW_LEN = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // sample_value[15:0], read_index[23:16]
  input  logic                 s_axis_tuser,  // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ZW-1:0]        m_axis_tdata,  // zscore[23:0]
  output logic                 m_axis_tuser   // valid_res
);

  localparam int NW  = $clog2(ROW_LEN + 1);
  localparam int AW  = $clog2(ROW_LEN);
  localparam int SW  = SAMPLE_W + NW;
  localparam int QW  = 2 * SAMPLE_W + NW;
  localparam int DW  = QW + NW;
  localparam int RW  = (DW + ROOT_FRAC_W + 1) / 2;
  localparam int PW  = 2 * RW;
  localparam int UW  = (RW + 2 > ROOT_W + 2) ? RW + 2 : ROOT_W + 2;
  localparam int RXW = (RW > ROOT_W) ? RW : ROOT_W + 1;
  localparam int CW  = $clog2(RW + 1);

  state_e              state_q, state_d;
  logic [NW-1:0]       fill_q, fill_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [QW-1:0]       sq_q, sq_d;
  logic                row_complete_q, row_complete_d;
  logic [ROOT_W-1:0]   scaled_root_q, scaled_root_d;
  logic                out_valid_q, out_valid_d;

  logic [DW-1:0]       nq_q, nq_d;
  logic [DW-1:0]       ss_q, ss_d;
  logic [PW-1:0]       x_q, x_d;
  logic [UW-1:0]       rem_q, rem_d;
  logic [RW-1:0]       root_q, root_d;
  logic [ZW-1:0]       quo_q, quo_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                neg_q, neg_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [ZW-1:0]       res_z_q, res_z_d;
  logic                res_vr_q, res_vr_d;
  logic [ZW-1:0]       out_z_q, out_z_d;
  logic                out_vr_q, out_vr_d;

  logic                s_acc;
  logic                idx_ok;
  logic [UW-1:0]       unit_a, unit_b, unit_diff;
  logic                unit_ge;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic [RXW-1:0]      root_x;
  logic [ZW-1:0]       quo_n;
  logic [ZW-1:0]       quo_clamp;
  logic [SW-1:0]       nx;
  logic [DW-1:0]       dvar;
  logic [2*SAMPLE_W-1:0] square;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign idx_ok = 32'(s_axis_tdata[IN_DATA_W-1:SAMPLE_W]) < ROW_LEN;

  // sample store
  assign mem_we    = (state_q == ST_ACCUM);
  assign mem_waddr = row_complete_q ? '0 : fill_q[AW-1:0];

  rzn_row_mem #(
    .DEPTH (ROW_LEN),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (sample_q),
    .raddr_i (AW'(idx_q)),
    .rdata_o (mem_rdata)
  );

  // operand select for the shared subtract unit
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state_q)
      ST_ROOT: begin
        unit_a = UW'({rem_q[RW-1:0], x_q[PW-1 -: 2]});
        unit_b = UW'({root_q, 2'b01});
      end
      ST_RANGE: begin
        unit_a = rem_q;
        unit_b = UW'(scaled_root_q);
      end
      ST_DIVIDE: begin
        unit_a = {rem_q[UW-2:0], 1'b0};
        unit_b = UW'(scaled_root_q);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  rzn_sub_unit #(
    .W (UW)
  ) u_sub (
    .a_i    (unit_a),
    .b_i    (unit_b),
    .ge_o   (unit_ge),
    .diff_o (unit_diff)
  );

  // datapath helpers
  assign square = (2*SAMPLE_W)'(sample_q) * (2*SAMPLE_W)'(sample_q);
  assign nx     = SW'(mem_rdata) * SW'(ROW_LEN);
  assign dvar   = (nq_q >= ss_q) ? (nq_q - ss_q) : '0;
  assign root_x = RXW'(root_q);
  assign quo_n  = {quo_q[ZW-2:0], unit_ge};

  // clamp the quotient to the signed result range
  always_comb begin
    if (neg_q) begin
      quo_clamp = (quo_n > Z_NEG_MAG) ? Z_NEG_MAG : quo_n;
      quo_clamp = '0 - quo_clamp;
    end else begin
      quo_clamp = quo_n[ZW-1] ? Z_POS_MAX : quo_n;
    end
  end

  // sequencer: next state and register updates
  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    sum_d          = sum_q;
    sq_d           = sq_q;
    row_complete_d = row_complete_q;
    scaled_root_d  = scaled_root_q;
    nq_d           = nq_q;
    ss_d           = ss_q;
    x_d            = x_q;
    rem_d          = rem_q;
    root_d         = root_q;
    quo_d          = quo_q;
    cnt_d          = cnt_q;
    neg_d          = neg_q;
    idx_d          = idx_q;
    sample_d       = sample_q;
    res_z_d        = res_z_q;
    res_vr_d       = res_vr_q;
    out_z_d        = out_z_q;
    out_vr_d       = out_vr_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    s_axis_tready  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_acc) begin
          if (s_axis_tuser == CMD_WRITE) begin
            sample_d = s_axis_tdata[SAMPLE_W-1:0];
            state_d  = ST_ACCUM;
          end else if (!row_complete_q || !idx_ok) begin
            res_z_d  = '0;
            res_vr_d = 1'b0;
            state_d  = ST_FINISH;
          end else if (scaled_root_q == '0) begin
            res_z_d  = '0;
            res_vr_d = 1'b1;
            state_d  = ST_FINISH;
          end else begin
            idx_d   = s_axis_tdata[IN_DATA_W-1:SAMPLE_W];
            state_d = ST_FETCH;
          end
        end
      end
      // store the sample and update the sums, restarting after a full row
      ST_ACCUM: begin
        if (row_complete_q) begin
          sum_d  = SW'(sample_q);
          sq_d   = QW'(square);
          fill_d = NW'(1);
        end else begin
          sum_d  = sum_q + SW'(sample_q);
          sq_d   = sq_q + QW'(square);
          fill_d = fill_q + NW'(1);
        end
        row_complete_d = 1'b0;
        state_d = (fill_d == NW'(ROW_LEN)) ? ST_SQUARE : ST_IDLE;
      end
      // n times q and s squared
      ST_SQUARE: begin
        nq_d    = DW'(sq_q) * DW'(ROW_LEN);
        ss_d    = DW'(sum_q) * DW'(sum_q);
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        x_d     = PW'({dvar, {ROOT_FRAC_W{1'b0}}});
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      // one root digit per cycle
      ST_ROOT: begin
        rem_d  = unit_ge ? unit_diff : unit_a;
        root_d = {root_q[RW-2:0], unit_ge};
        x_d    = x_q << 2;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(RW - 1)) begin
          state_d = ST_SAVE;
        end
      end
      ST_SAVE: begin
        scaled_root_d  = (|root_x[RXW-1:ROOT_W]) ? '1 : root_x[ROOT_W-1:0];
        row_complete_d = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_FETCH: begin
        state_d = ST_PREP;
      end
      // signed distance of n times x from the sum
      ST_PREP: begin
        neg_d   = nx < sum_q;
        rem_d   = UW'(neg_d ? (sum_q - nx) : (nx - sum_q));
        state_d = ST_RANGE;
      end
      // a magnitude at or above the root saturates the result
      ST_RANGE: begin
        if (unit_ge) begin
          res_z_d  = neg_q ? Z_NEG_MAG : Z_POS_MAX;
          res_vr_d = 1'b1;
          state_d  = ST_FINISH;
        end else begin
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIVIDE;
        end
      end
      // one quotient bit per cycle
      ST_DIVIDE: begin
        rem_d = unit_ge ? unit_diff : unit_a;
        quo_d = quo_n;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(ZW - 1)) begin
          res_z_d  = quo_clamp;
          res_vr_d = 1'b1;
          state_d  = ST_FINISH;
        end
      end
      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_z_d     = res_z_q;
          out_vr_d    = res_vr_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      fill_q         <= '0;
      sum_q          <= '0;
      sq_q           <= '0;
      row_complete_q <= 1'b0;
      scaled_root_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      fill_q         <= fill_d;
      sum_q          <= sum_d;
      sq_q           <= sq_d;
      row_complete_q <= row_complete_d;
      scaled_root_q  <= scaled_root_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    nq_q     <= nq_d;
    ss_q     <= ss_d;
    x_q      <= x_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    neg_q    <= neg_d;
    idx_q    <= idx_d;
    sample_q <= sample_d;
    res_z_q  <= res_z_d;
    res_vr_q <= res_vr_d;
    out_z_q  <= out_z_d;
    out_vr_q <= out_vr_d;
  end

  // output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_z_q;
  assign m_axis_tuser  = out_vr_q;

endmodule

/* src/rzn_checker.sv */
// port-level checks of the row z-score normalizer, bound to the top level
module rzn_checker
  import rzn_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [ZW-1:0]        m_axis_tdata,
  input logic                 m_axis_tuser
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an invalid result carries a zero z-score
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero z-score");

  // the block works on one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request taken while busy");

  // no result appears in the cycle right after a request
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind row_zscore_normalizer_top rzn_checker u_rzn_checker (.*);
